[src/hcac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hcac_pkg;

  localparam int FracBits = 16;
  localparam int Terms = 16;
  localparam int IntLimit = 40;
  localparam int IntBits = 6;
  localparam int FBits = 30;
  localparam int PowSteps = IntLimit - 1;
  localparam logic [31:0] ExpNegOne = 32'd790015085;
  localparam logic [31:0] OneQ31 = 32'h8000_0000;

  localparam logic [1:0] RegMean = 2'd0;
  localparam logic [1:0] RegSpread = 2'd1;
  localparam logic [1:0] RegScale = 2'd2;
  localparam logic [1:0] RegKeep = 2'd3;

  typedef struct packed {
    logic        wr;
    logic        scale;
    logic        less;
    logic [31:0] raw;
    logic [7:0]  ival;
  } side_t;

  typedef struct packed {
    logic [20:0] mean;
    logic [31:0] spread;
    logic        scale;
    logic        keep;
  } cfg_t;

endpackage
`default_nettype wire

[src/hcac_avg.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcac_avg (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [7:0]      count,
  input  logic [31:0]     hsum,
  input  logic [15:0]     isum,
  input  hcac_pkg::cfg_t  cfg,
  output logic            out_valid,
  output hcac_pkg::side_t out_side
);
  import hcac_pkg::*;

  localparam int Stages = 8;
  localparam int HStep = 4;
  localparam int IStep = 2;

  logic [Stages:0] v;
  logic [7:0]      cnt [Stages+1];
  logic            neg [Stages+1];
  logic [7:0]      hr  [Stages+1];
  logic [31:0]     hq  [Stages+1];
  logic [7:0]      ir  [Stages+1];
  logic [15:0]     iq  [Stages+1];

  function automatic logic [39:0] hstep(input logic [39:0] st, input logic [7:0] c);
    logic [8:0]  t;
    logic [31:0] n;
    t = {st[39:32], st[31]};
    n = {st[30:0], 1'b0};
    if (t >= {1'b0, c}) begin
      t = t - {1'b0, c};
      n[0] = 1'b1;
    end
    return {t[7:0], n};
  endfunction

  function automatic logic [23:0] istep(input logic [23:0] st, input logic [7:0] c);
    logic [8:0]  t;
    logic [15:0] n;
    t = {st[23:16], st[15]};
    n = {st[14:0], 1'b0};
    if (t >= {1'b0, c}) begin
      t = t - {1'b0, c};
      n[0] = 1'b1;
    end
    return {t[7:0], n};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt[0] <= count;
      neg[0] <= hsum[31];
      hq[0]  <= hsum[31] ? (~hsum + 32'd1) : hsum;
      hr[0]  <= '0;
      iq[0]  <= isum;
      ir[0]  <= '0;
    end
  end

  for (genvar s = 1; s <= Stages; s++) begin : g_stage
    logic [39:0] hs;
    logic [23:0] is;

    always_comb begin
      hs = {hr[s-1], hq[s-1]};
      for (int i = 0; i < HStep; i++) hs = hstep(hs, cnt[s-1]);
      is = {ir[s-1], iq[s-1]};
      for (int i = 0; i < IStep; i++) is = istep(is, cnt[s-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cnt[s] <= cnt[s-1];
        neg[s] <= neg[s-1];
        hr[s]  <= hs[39:32];
        hq[s]  <= hs[31:0];
        ir[s]  <= is[23:16];
        iq[s]  <= is[15:0];
      end
    end
  end

  logic        empty;
  logic [31:0] z;

  assign empty = (cnt[Stages] == 8'd0);
  assign z = neg[Stages] ? (~hq[Stages] + 32'd1) : hq[Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[Stages];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side.wr    <= !empty || !cfg.keep;
      out_side.scale <= !empty && cfg.scale;
      out_side.less  <= 1'b0;
      out_side.raw   <= empty ? 32'd0 : z;
      out_side.ival  <= empty ? 8'd0 : iq[Stages][7:0];
    end
  end

endmodule
`default_nettype wire

[src/hcac_quot.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcac_quot (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  hcac_pkg::side_t in_side,
  input  hcac_pkg::cfg_t  cfg,
  output logic            out_valid,
  output hcac_pkg::side_t out_side,
  output logic            out_sat,
  output logic [5:0]      out_q,
  output logic [29:0]     out_f
);
  import hcac_pkg::*;

  logic [32:0] den;
  logic [38:0] den40;

  assign den = {((cfg.spread == 32'd0) ? 32'd1 : cfg.spread), 1'b0};
  assign den40 = 39'(den) * 39'd40;

  logic        v1, v2, v3;
  side_t       sd1, sd2;
  logic [32:0] ad1;
  logic [63:0] d22;
  logic [32:0] d;

  assign d = {in_side.raw[31], in_side.raw} - {{12{cfg.mean[20]}}, cfg.mean};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  logic [IntBits:0] iv;
  side_t            isd  [IntBits+1];
  logic             isat [IntBits+1];
  logic [38:0]      irem [IntBits+1];
  logic [5:0]       iqq  [IntBits+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1 <= '{wr: in_side.wr, scale: in_side.scale, less: d[32], raw: in_side.raw,
               ival: in_side.ival};
      ad1 <= d[32] ? (~d + 33'd1) : d;
      sd2 <= sd1;
      d22 <= 64'(ad1) * 64'(ad1);
      isd[0]  <= sd2;
      isat[0] <= d22 >= {25'd0, den40};
      irem[0] <= d22[38:0];
      iqq[0]  <= '0;
    end
  end

  assign iv[0] = v3;

  for (genvar j = 0; j < IntBits; j++) begin : g_int
    logic [38:0] dd;
    logic        hit;

    assign dd = 39'(den) << (IntBits - 1 - j);
    assign hit = irem[j] >= dd;

    always_ff @(posedge clk) begin
      if (rst) begin
        iv[j+1] <= 1'b0;
      end else if (adv) begin
        iv[j+1] <= iv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        isd[j+1]  <= isd[j];
        isat[j+1] <= isat[j];
        irem[j+1] <= hit ? (irem[j] - dd) : irem[j];
        iqq[j+1]  <= {iqq[j][4:0], hit};
      end
    end
  end

  logic [FBits-1:0] fv;
  side_t            fsd  [FBits];
  logic             fsat [FBits];
  logic [32:0]      frem [FBits];
  logic [5:0]       fqq  [FBits];
  logic [29:0]      fff  [FBits];

  for (genvar j = 0; j < FBits; j++) begin : g_frac
    logic        pv;
    side_t       psd;
    logic        psat;
    logic [32:0] prem;
    logic [5:0]  pqq;
    logic [29:0] pff;
    logic [33:0] t;
    logic        hit;

    if (j == 0) begin : g_first
      assign pv   = iv[IntBits];
      assign psd  = isd[IntBits];
      assign psat = isat[IntBits];
      assign prem = irem[IntBits][32:0];
      assign pqq  = iqq[IntBits];
      assign pff  = '0;
    end else begin : g_next
      assign pv   = fv[j-1];
      assign psd  = fsd[j-1];
      assign psat = fsat[j-1];
      assign prem = frem[j-1];
      assign pqq  = fqq[j-1];
      assign pff  = fff[j-1];
    end

    assign t = {prem, 1'b0};
    assign hit = t >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        fv[j] <= 1'b0;
      end else if (adv) begin
        fv[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fsd[j]  <= psd;
        fsat[j] <= psat;
        frem[j] <= hit ? 33'(t - {1'b0, den}) : t[32:0];
        fqq[j]  <= pqq;
        fff[j]  <= {pff[28:0], hit};
      end
    end
  end

  assign out_valid = fv[FBits-1];
  assign out_side  = fsd[FBits-1];
  assign out_sat   = fsat[FBits-1];
  assign out_q     = fqq[FBits-1];
  assign out_f     = fff[FBits-1];

endmodule
`default_nettype wire

[src/hcac_series.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcac_series (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  hcac_pkg::side_t in_side,
  input  logic            in_sat,
  input  logic [5:0]      in_q,
  input  logic [29:0]     in_f,
  output logic            out_valid,
  output hcac_pkg::side_t out_side,
  output logic            out_sat,
  output logic [5:0]      out_q,
  output logic [33:0]     out_sum
);
  import hcac_pkg::*;

  logic [Terms-1:0] bv;
  side_t            bsd  [Terms];
  logic             bsat [Terms];
  logic [5:0]       bq   [Terms];
  logic [29:0]      bf   [Terms];
  logic [31:0]      bt   [Terms];
  logic [33:0]      bs   [Terms];

  for (genvar k = 1; k <= Terms; k++) begin : g_term
    localparam logic [31:0] Mul = 32'(64'd4294967296 / 64'(k));

    logic        pv;
    side_t       psd;
    logic        psat;
    logic [5:0]  pq;
    logic [29:0] pf;
    logic [31:0] pt;
    logic [33:0] ps;

    if (k == 1) begin : g_first
      assign pv   = in_valid;
      assign psd  = in_side;
      assign psat = in_sat;
      assign pq   = in_q;
      assign pf   = in_f;
      assign pt   = OneQ31;
      assign ps   = {2'b00, OneQ31};
    end else begin : g_next
      assign pv   = bv[k-2];
      assign psd  = bsd[k-2];
      assign psat = bsat[k-2];
      assign pq   = bq[k-2];
      assign pf   = bf[k-2];
      assign pt   = bt[k-2];
      assign ps   = bs[k-2];
    end

    logic        va, vb;
    side_t       sda, sdb;
    logic        sata, satb;
    logic [5:0]  qa, qb;
    logic [29:0] fa, fb;
    logic [33:0] sa, sb;
    logic [61:0] pa;
    logic [31:0] xb;
    logic [63:0] mb;
    logic [31:0] qh;
    logic [31:0] r;
    logic [31:0] tk;

    assign qh = mb[63:32];
    assign r  = xb - 32'(qh * 32'(k));
    assign tk = (k == 1) ? xb : (qh + {31'd0, (r >= 32'(k))});

    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
        vb <= 1'b0;
        bv[k-1] <= 1'b0;
      end else if (adv) begin
        va <= pv;
        vb <= va;
        bv[k-1] <= vb;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sda  <= psd;
        sata <= psat;
        qa   <= pq;
        fa   <= pf;
        sa   <= ps;
        pa   <= 62'(pt) * 62'(pf);
        sdb  <= sda;
        satb <= sata;
        qb   <= qa;
        fb   <= fa;
        sb   <= sa;
        xb   <= pa[61:30];
        mb   <= 64'(pa[61:30]) * 64'(Mul);
        bsd[k-1]  <= sdb;
        bsat[k-1] <= satb;
        bq[k-1]   <= qb;
        bf[k-1]   <= fb;
        bt[k-1]   <= tk;
        bs[k-1]   <= (k % 2 == 1) ? (sb - {2'b00, tk}) : (sb + {2'b00, tk});
      end
    end
  end

  assign out_valid = bv[Terms-1];
  assign out_side  = bsd[Terms-1];
  assign out_sat   = bsat[Terms-1];
  assign out_q     = bq[Terms-1];
  assign out_sum   = bs[Terms-1];

endmodule
`default_nettype wire

[src/hcac_power.sv]
`timescale 1ns / 1ps
`default_nettype none
module hcac_power (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  hcac_pkg::side_t in_side,
  input  logic            in_sat,
  input  logic [5:0]      in_q,
  input  logic [33:0]     in_sum,
  output logic            out_valid,
  output hcac_pkg::side_t out_side,
  output logic            out_sat,
  output logic [31:0]     out_e
);
  import hcac_pkg::*;

  logic [PowSteps:0] v;
  side_t             sd  [PowSteps+1];
  logic              sat [PowSteps+1];
  logic [5:0]        q   [PowSteps+1];
  logic [31:0]       e   [PowSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0]  <= in_side;
      sat[0] <= in_sat;
      q[0]   <= in_q;
      e[0]   <= in_sum[33] ? 32'd0 : in_sum[31:0];
    end
  end

  for (genvar i = 0; i < PowSteps; i++) begin : g_mul
    logic [61:0] p;

    assign p = 62'(e[i]) * 62'(ExpNegOne) + 62'(OneQ31 >> 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[i+1]  <= sd[i];
        sat[i+1] <= sat[i];
        q[i+1]   <= q[i];
        e[i+1]   <= (6'(i) < q[i]) ? 32'(p >> 31) : e[i];
      end
    end
  end

  assign out_valid = v[PowSteps];
  assign out_side  = sd[PowSteps];
  assign out_sat   = sat[PowSteps];
  assign out_e     = e[PowSteps];

endmodule
`default_nettype wire

[src/height_cell_average_contrast.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  tdata (low bit up)                           tuser
// s_*       in         point_count[7:0] height_sum[31:0]            -
//                      intensity_sum[15:0]
// m_*       out        height_value[31:0] intensity_value[7:0]      write_cell
// cfg_*     in         write: index 0 mean, 1 spread, 2 scale, 3 keep
//
// One item per cycle unless the output stalls. Stages in order: count divider,
// square and spread divider (one quotient bit per stage), the sixteen series
// terms (three stages each), the exp(-1) powers, then the output register.
// Reset clears all valid bits and loads the register defaults.
// A stall on the output freezes the whole pipeline; s_tready follows it.
module height_cell_average_contrast (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // point_count, height_sum, intensity_sum
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // height_value, intensity_value
  output logic        m_tuser,   // write_cell
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hcac_pkg::*;

  cfg_t  cfg;
  logic  adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mean   <= '0;
      cfg.spread <= 32'd1000000;
      cfg.scale  <= 1'b0;
      cfg.keep   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMean:   cfg.mean   <= cfg_data[20:0];
        RegSpread: cfg.spread <= cfg_data;
        RegScale:  cfg.scale  <= cfg_data[0];
        RegKeep:   cfg.keep   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic        a_v;
  side_t       a_sd;

  hcac_avg u_avg (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_tvalid && s_tready),
    .count(s_tdata[7:0]), .hsum(s_tdata[39:8]), .isum(s_tdata[55:40]),
    .cfg(cfg), .out_valid(a_v), .out_side(a_sd)
  );

  logic        q_v, q_sat;
  side_t       q_sd;
  logic [5:0]  q_q;
  logic [29:0] q_f;

  hcac_quot u_quot (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(a_v), .in_side(a_sd), .cfg(cfg),
    .out_valid(q_v), .out_side(q_sd), .out_sat(q_sat), .out_q(q_q), .out_f(q_f)
  );

  logic        s_v, s_sat;
  side_t       s_sd;
  logic [5:0]  s_q;
  logic [33:0] s_sum;

  hcac_series u_series (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(q_v), .in_side(q_sd),
    .in_sat(q_sat), .in_q(q_q), .in_f(q_f),
    .out_valid(s_v), .out_side(s_sd), .out_sat(s_sat), .out_q(s_q), .out_sum(s_sum)
  );

  logic        p_v, p_sat;
  side_t       p_sd;
  logic [31:0] p_e;

  hcac_power u_power (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(s_v), .in_side(s_sd),
    .in_sat(s_sat), .in_q(s_q), .in_sum(s_sum),
    .out_valid(p_v), .out_side(p_sd), .out_sat(p_sat), .out_e(p_e)
  );

  logic [31:0] e_eff;
  logic [31:0] half;
  logic [31:0] cv;
  logic [32:0] rnd;
  logic [31:0] hv;

  assign e_eff = p_sat ? 32'd0 : p_e;
  assign half  = {1'b0, e_eff[31:1]};
  assign cv    = p_sd.less ? half : (OneQ31 - half);
  assign rnd   = ({1'b0, cv} + (33'd1 << (30 - FracBits))) >> (31 - FracBits);
  assign hv    = p_sd.scale ? rnd[31:0] : p_sd.raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {p_sd.ival, hv};
      m_tuser <= p_sd.wr;
    end
  end

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import hcac_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int Drain = 160;

  class cell_scoreboard;
    typedef struct {
      bit          wr;
      logic [31:0] hv;
      logic [7:0]  iv;
    } cell_out_t;

    logic signed [20:0] mean;
    logic [31:0]        spread;
    bit                 scale;
    bit                 keep;
    cell_out_t          pending[$];
    int                 errors;

    function new();
      mean = 0;
      spread = 32'd1000000;
      scale = 0;
      keep = 0;
      errors = 0;
    endfunction

    function longint unsigned exp_neg(longint unsigned f);
      longint sum;
      longint unsigned term;
      sum = longint'(OneQ31);
      term = 64'h8000_0000;
      for (int k = 1; k <= 16; k++) begin
        term = ((term * f) >> 30) / longint'(k);
        if (k % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      return longint'(sum);
    endfunction

    function logic [31:0] contrast(longint z);
      longint d, m;
      longint unsigned ad, d2, den, q, r, f, e, einv, v;
      m = longint'(mean);
      d = z - m;
      ad = d < 0 ? -d : d;
      d2 = ad * ad;
      den = (spread == 0) ? 64'd2 : {32'd0, spread} * 2;
      q = d2 / den;
      r = d2 % den;
      f = (r << 30) / den;
      if (q >= 40) begin
        e = 0;
      end else begin
        einv = exp_neg(64'd1 << 30);
        e = exp_neg(f);
        for (longint unsigned i = 0; i < q; i++) e = (e * einv + (64'd1 << 30)) >> 31;
      end
      if (z < m) v = e >> 1;
      else v = (64'd1 << 31) - (e >> 1);
      return 32'((v + (64'd1 << 14)) >> 15);
    endfunction

    function void note(logic [7:0] cnt, logic [31:0] hs, logic [15:0] isum);
      cell_out_t c;
      longint z;
      if (cnt == 0) begin
        c.wr = !keep;
        c.hv = 0;
        c.iv = 0;
      end else begin
        z = longint'($signed(hs)) / longint'({56'd0, cnt});
        c.wr = 1;
        c.hv = scale ? contrast(z) : 32'(z);
        c.iv = 8'(isum / cnt);
      end
      pending.push_back(c);
    endfunction

    function void check(bit wr, logic [31:0] hv, logic [7:0] iv);
      cell_out_t c;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: wr %0b hv %h iv %h", wr, hv, iv);
        return;
      end
      c = pending.pop_front();
      if (c.wr !== wr || c.hv !== hv || c.iv !== iv) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected wr %0b hv %h iv %h, got wr %0b hv %h iv %h",
                   c.wr, c.hv, c.iv, wr, hv, iv);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cell_scoreboard sb;
  bit             calm;
  int             cycles;

  height_cell_average_contrast DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_cell(logic [7:0] cnt, logic [31:0] hs, logic [15:0] isum);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {isum, hs, cnt};
    do @(posedge clk); while (!s_tready);
    sb.note(cnt, hs, isum);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      RegMean: sb.mean = val[20:0];
      RegSpread: sb.spread = val;
      RegScale: sb.scale = val[0];
      default: sb.keep = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic random_cell();
    int kind, cnt, mag;
    longint z, hs;
    kind = $urandom_range(0, 9);
    cnt = $urandom_range(1, 255);
    if (kind == 0) begin
      send_cell(0, $urandom, 16'($urandom));
    end else if (kind <= 3) begin
      send_cell(8'(cnt), $urandom, 16'($urandom));
    end else begin
      mag = 1 << $urandom_range(0, 20);
      z = longint'(sb.mean) + longint'($urandom_range(0, 2 * mag)) - mag;
      hs = z * cnt + (z < 0 ? -1 : 1) * longint'($urandom_range(0, cnt - 1));
      if (hs > 64'sd2147483647 || hs < -64'sd2147483648) hs = longint'($signed($urandom));
      send_cell(8'(cnt), 32'(hs), 16'($urandom));
    end
  endtask

  initial begin
    forever begin
      int stall;
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!(m_tvalid && !rst));
      sb.check(m_tuser, m_tdata[31:0], m_tdata[39:32]);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_cell(0, 32'hFFFF_FFFF, 16'hFFFF);
    send_cell(1, 32'h7FFF_FFFF, 16'hFFFF);
    send_cell(1, 32'h8000_0000, 16'd255);
    send_cell(255, 32'h7FFF_FFFF, 16'hFFFF);
    send_cell(255, 32'h8000_0000, 16'd0);
    send_cell(3, -32'sd7, 16'd10);
    send_cell(3, 32'd7, 16'd1000);
    send_cell(255, 32'd254, 16'd254);
    settle();

    write_reg(RegScale, 1);
    write_reg(RegSpread, 32'd1000000);
    write_reg(RegMean, 0);
    write_reg(RegKeep, 1);
    send_cell(0, 0, 0);
    send_cell(1, 0, 16'd3);
    send_cell(1, -32'sd1, 16'd3);
    send_cell(1, 32'd1000, 16'd3);
    send_cell(1, -32'sd1000, 16'd3);
    send_cell(2, 32'd3000, 16'd3);
    send_cell(1, 32'h7FFF_FFFF, 16'd3);
    send_cell(1, 32'h8000_0000, 16'd3);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(RegMean, -32'sd1000000); write_reg(RegSpread, 1); end
        1: begin write_reg(RegMean, 32'd1000000); write_reg(RegSpread, 32'hFFFF_FFFF); end
        2: begin write_reg(RegMean, $urandom); write_reg(RegSpread, 0); end
        3: begin
          write_reg(RegMean, $urandom_range(0, 2000) - 1000);
          write_reg(RegSpread, $urandom_range(1, 5000));
        end
        4: write_reg(RegScale, 0);
        5: begin
          write_reg(RegScale, 1);
          write_reg(RegMean, $urandom_range(0, 2000000) - 1000000);
          write_reg(RegSpread, $urandom);
        end
        6: write_reg(RegSpread, $urandom_range(1, 1 << 20));
        default: write_reg(RegMean, $urandom_range(0, 200000) - 100000);
      endcase
      write_reg(RegKeep, $urandom_range(0, 1));
      calm = (phase % 3 == 2);
      for (int n = 0; n < 215; n++) random_cell();
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
